// File: hw/rtl/wca_pkg.sv
// Package: shared types and constants of the weighted centroid accumulator.
`timescale 1ns / 1ps
`default_nettype none
package wca_pkg;

  localparam int MAX_CELLS = 2048;
  localparam int MAX_DIM   = 4096;
  localparam int CELL_AW   = $clog2(MAX_CELLS);

  // Accumulator widths
  localparam int MASS_W = 32;
  localparam int MOM_W  = 44;
  localparam int AREA_W = 25;
  localparam int ASQ_W  = 49;
  localparam int SPR_W  = 28;
  localparam int ENTRY_W = MASS_W + 2 * MOM_W + AREA_W;

  // Iterative units
  localparam int DIV_N    = 69;   // dividend bits
  localparam int DEN_W    = 32;   // divisor bits
  localparam int SQ_IN_W  = 58;   // radicand bits
  localparam int SQ_STEPS = SQ_IN_W / 2;

  // Modes
  localparam logic [1:0] MODE_ACC    = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  // Register indexes
  localparam logic [1:0] CFG_CELL_COUNT    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd2;
  localparam logic [1:0] CFG_DENSITY_FLOOR = 2'd3;

  localparam logic KIND_CENTROID = 1'b0;
  localparam logic KIND_STATS    = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  gray;
    logic [10:0] cell_req;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [10:0]       cell_out;
    logic [15:0]       point_x;
    logic [15:0]       point_y;
    logic [AREA_W-1:0] area;
    logic [SPR_W-1:0]  spread;
    logic [SPR_W-1:0]  spread_change;
  } out_word_t;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [MOM_W-1:0]  xm;
    logic [MOM_W-1:0]  ym;
    logic [AREA_W-1:0] area;
  } entry_t;

endpackage
`default_nettype wire

// File: hw/rtl/wca_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module wca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/weighted_centroid_accumulator.sv
// Top level: weighted Lloyd step accumulator with centroid and spread readout.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block sweeps its 2048-entry cell memory to zero, one entry
// a cycle, and takes no word until the sweep ends. A pixel word (mode 0)
// then makes one memory read and one write-back, and the next word is not
// taken until that write-back is done. A cell readout (mode 1) runs two
// 69-step passes of the shared bit-serial divider for x and y. A frame
// finish (mode 2) runs one divider pass and a 29-step bit-serial square
// root. An unused mode code is dropped with no result. A new word is taken
// while a finished result still waits at the output register.
module weighted_centroid_accumulator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wca_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wca_pkg::out_word_t      out_word,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [12:0]        cfg_wdata
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RMW, S_SQ, S_ACC, S_DIVX, S_DIVY,
    S_M2A, S_M2B, S_M2C, S_DIVV, S_SQRT, S_FIN, S_OUT
  } state_t;

  state_t st_r;

  // Configuration
  logic [11:0] cell_count_r;
  logic [12:0] image_width_r, image_height_r;
  logic [7:0]  density_floor_r;

  // Item and cell values
  wca_pkg::in_word_t item_r;
  logic                             cell_ok_r;
  logic [wca_pkg::CELL_AW-1:0]      clr_cnt_r;
  logic [wca_pkg::MASS_W-1:0]       mass_r;
  logic [wca_pkg::MOM_W-1:0]        xm_r, ym_r;
  logic [wca_pkg::AREA_W-1:0]       a_r;
  logic [2*wca_pkg::AREA_W-1:0]     sq_r;
  logic [15:0]                      px_r, py_r;

  // Frame statistics
  logic [wca_pkg::AREA_W-1:0] area_sum_r;
  logic [wca_pkg::ASQ_W-1:0]  asq_sum_r;
  logic [wca_pkg::SPR_W-1:0]  prev_spread_r;
  logic [11:0]                n_r;
  logic [2*wca_pkg::AREA_W-1:0] s2_r;
  logic [36:0]                plo_r;
  logic [35:0]                phi_r;
  logic [23:0]                n2_r;
  logic [wca_pkg::SPR_W-1:0]  sp_r, ch_r;

  // Divider and root
  logic [wca_pkg::DIV_N-1:0]  div_quo_r;
  logic [wca_pkg::DEN_W-1:0]  div_rem_r, div_den_r;
  logic [6:0]                 div_cnt_r;
  logic [wca_pkg::SQ_IN_W-1:0] sq_op_r;
  logic [30:0]                sq_rem_r;
  logic [28:0]                sq_root_r;
  logic [4:0]                 sq_cnt_r;

  wca_pkg::out_word_t out_r;
  logic               out_valid_r;

  // Memory
  logic                         ram_we, ram_re;
  logic [wca_pkg::CELL_AW-1:0]  ram_waddr, ram_raddr;
  wca_pkg::entry_t              ram_wdata, ram_rdata;

  wca_ram #(.WIDTH(wca_pkg::ENTRY_W), .DEPTH(wca_pkg::MAX_CELLS)) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  logic in_acc;
  assign in_ready  = (st_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign ram_re    = in_acc;
  assign ram_raddr = wca_pkg::CELL_AW'(in_word.cell_req);

  // Pixel update
  logic [7:0]                 dens;
  logic [19:0]                xprod, yprod;
  logic [wca_pkg::MASS_W:0]   mass_sum;
  logic [wca_pkg::MOM_W:0]    xm_sum, ym_sum;
  logic [wca_pkg::AREA_W:0]   area_inc;
  wca_pkg::entry_t            acc_entry;

  always_comb begin
    dens = 8'd255 - item_r.gray;
    if (dens < density_floor_r) begin
      dens = density_floor_r;
    end
    xprod    = item_r.pixel_x * dens;
    yprod    = item_r.pixel_y * dens;
    mass_sum = {1'b0, ram_rdata.mass} + (wca_pkg::MASS_W + 1)'(dens);
    xm_sum   = {1'b0, ram_rdata.xm} + (wca_pkg::MOM_W + 1)'(xprod);
    ym_sum   = {1'b0, ram_rdata.ym} + (wca_pkg::MOM_W + 1)'(yprod);
    area_inc = {1'b0, ram_rdata.area} + (wca_pkg::AREA_W + 1)'(1);
    acc_entry.mass = mass_sum[wca_pkg::MASS_W] ? '1 : mass_sum[wca_pkg::MASS_W-1:0];
    acc_entry.xm   = xm_sum[wca_pkg::MOM_W] ? '1 : xm_sum[wca_pkg::MOM_W-1:0];
    acc_entry.ym   = ym_sum[wca_pkg::MOM_W] ? '1 : ym_sum[wca_pkg::MOM_W-1:0];
    acc_entry.area = area_inc[wca_pkg::AREA_W] ? '1 : area_inc[wca_pkg::AREA_W-1:0];
  end

  // Memory write: clear sweep, pixel add, readout clear
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    if (st_r == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (st_r == S_RMW) begin
      ram_we    = cell_ok_r;
      ram_waddr = wca_pkg::CELL_AW'(item_r.cell_req);
      if (item_r.mode == wca_pkg::MODE_ACC) begin
        ram_wdata = acc_entry;
      end
    end
  end

  // Divider step (restoring, one quotient bit a cycle)
  logic [wca_pkg::DEN_W:0]   div_sh;
  logic                      div_ge;
  logic [wca_pkg::DEN_W-1:0] div_rem_nxt;
  logic [wca_pkg::DIV_N-1:0] div_quo_nxt;
  logic                      div_last;

  always_comb begin
    div_sh      = {div_rem_r, div_quo_r[wca_pkg::DIV_N-1]};
    div_ge      = div_sh >= {1'b0, div_den_r};
    div_rem_nxt = div_ge ? wca_pkg::DEN_W'(div_sh - {1'b0, div_den_r})
                         : div_sh[wca_pkg::DEN_W-1:0];
    div_quo_nxt = {div_quo_r[wca_pkg::DIV_N-2:0], div_ge};
    div_last    = (div_cnt_r == 7'(wca_pkg::DIV_N - 1));
  end

  // Root step (two radicand bits a cycle)
  logic [32:0] sq_sh, sq_trial;
  logic        sq_ge;
  logic [30:0] sq_rem_nxt;
  logic [28:0] sq_root_nxt;

  always_comb begin
    sq_sh       = {sq_rem_r, sq_op_r[wca_pkg::SQ_IN_W-1 -: 2]};
    sq_trial    = 33'({sq_root_r, 2'b01});
    sq_ge       = sq_sh >= sq_trial;
    sq_rem_nxt  = sq_ge ? 31'(sq_sh - sq_trial) : sq_sh[30:0];
    sq_root_nxt = {sq_root_r[27:0], sq_ge};
  end

  // Clamp a quotient to min(dim*16, 65535), or give 0 for a zero divisor
  function automatic logic [15:0] clamp_pt(input logic [wca_pkg::DIV_N-1:0] q,
                                           input logic [12:0] dim,
                                           input logic zero_den);
    logic [16:0] cap;
    begin
      cap = {dim, 4'b0000};
      if (cap > 17'd65535) begin
        cap = 17'd65535;
      end
      if (zero_den) begin
        clamp_pt = 16'd0;
      end else if (q > wca_pkg::DIV_N'(cap)) begin
        clamp_pt = cap[15:0];
      end else begin
        clamp_pt = q[15:0];
      end
    end
  endfunction

  // Statistic sums
  logic [wca_pkg::AREA_W:0]  asum_nxt;
  logic [50:0]               asq_nxt;
  logic [60:0]               ns, dv;
  logic [28:0]               sp_sat;

  always_comb begin
    asum_nxt = {1'b0, area_sum_r} + {1'b0, a_r};
    asq_nxt  = 51'(asq_sum_r) + 51'(sq_r);
    ns       = 61'(plo_r) + (61'(phi_r) << 25);
    dv       = (ns > 61'(s2_r)) ? ns - 61'(s2_r) : 61'd0;
    sp_sat   = sq_root_r;
    if (sp_sat > 29'(2**wca_pkg::SPR_W - 1)) begin
      sp_sat = 29'(2**wca_pkg::SPR_W - 1);
    end
  end

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r            <= S_CLEAR;
      clr_cnt_r       <= '0;
      out_valid_r     <= 1'b0;
      area_sum_r      <= '0;
      asq_sum_r       <= '0;
      prev_spread_r   <= '0;
      cell_count_r    <= 12'd1280;
      image_width_r   <= 13'd4096;
      image_height_r  <= 13'd4096;
      density_floor_r <= 8'd3;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          wca_pkg::CFG_CELL_COUNT:    cell_count_r    <= cfg_wdata[11:0];
          wca_pkg::CFG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata;
          wca_pkg::CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_wdata;
          wca_pkg::CFG_DENSITY_FLOOR: density_floor_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end

      // The output state reloads the word itself
      if (out_valid_r && out_ready && st_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == wca_pkg::CELL_AW'(wca_pkg::MAX_CELLS - 1)) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            item_r    <= in_word;
            cell_ok_r <= int'(in_word.cell_req) < wca_pkg::MAX_CELLS;
            case (in_word.mode)
              wca_pkg::MODE_ACC, wca_pkg::MODE_READ: st_r <= S_RMW;
              wca_pkg::MODE_FINISH: st_r <= S_M2A;
              default: st_r <= S_IDLE;
            endcase
          end
        end
        S_RMW: begin
          if (item_r.mode == wca_pkg::MODE_ACC) begin
            st_r <= S_IDLE;
          end else begin
            if (cell_ok_r) begin
              mass_r <= ram_rdata.mass;
              xm_r   <= ram_rdata.xm;
              ym_r   <= ram_rdata.ym;
              a_r    <= ram_rdata.area;
            end else begin
              mass_r <= '0;
              xm_r   <= '0;
              ym_r   <= '0;
              a_r    <= '0;
            end
            st_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= a_r * a_r;
          if (mass_r < wca_pkg::MASS_W'(density_floor_r)) begin
            mass_r <= wca_pkg::MASS_W'(density_floor_r);
          end
          st_r <= S_ACC;
        end
        S_ACC: begin
          area_sum_r <= asum_nxt[wca_pkg::AREA_W] ? '1 : asum_nxt[wca_pkg::AREA_W-1:0];
          asq_sum_r  <= (asq_nxt[50:wca_pkg::ASQ_W] != '0) ? '1
                                                          : asq_nxt[wca_pkg::ASQ_W-1:0];
          div_quo_r  <= wca_pkg::DIV_N'({xm_r, 4'b0000});
          div_den_r  <= mass_r;
          div_rem_r  <= '0;
          div_cnt_r  <= '0;
          st_r       <= S_DIVX;
        end
        S_DIVX: begin
          if (div_last) begin
            px_r      <= clamp_pt(div_quo_nxt, image_width_r, div_den_r == '0);
            div_quo_r <= wca_pkg::DIV_N'({ym_r, 4'b0000});
            div_rem_r <= '0;
            div_cnt_r <= '0;
            st_r      <= S_DIVY;
          end else begin
            div_quo_r <= div_quo_nxt;
            div_rem_r <= div_rem_nxt;
            div_cnt_r <= div_cnt_r + 1'b1;
          end
        end
        S_DIVY: begin
          div_quo_r <= div_quo_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_last) begin
            py_r <= clamp_pt(div_quo_nxt, image_height_r, div_den_r == '0);
            st_r <= S_OUT;
          end
        end
        S_M2A: begin
          n_r   <= (cell_count_r == '0) ? 12'd1 : cell_count_r;
          s2_r  <= area_sum_r * area_sum_r;
          st_r  <= S_M2B;
        end
        S_M2B: begin
          plo_r <= n_r * asq_sum_r[24:0];
          phi_r <= n_r * asq_sum_r[48:25];
          n2_r  <= n_r * n_r;
          st_r  <= S_M2C;
        end
        S_M2C: begin
          div_quo_r <= {dv, 8'h00};
          div_den_r <= wca_pkg::DEN_W'(n2_r);
          div_rem_r <= '0;
          div_cnt_r <= '0;
          st_r      <= S_DIVV;
        end
        S_DIVV: begin
          div_quo_r <= div_quo_nxt;
          div_rem_r <= div_rem_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_last) begin
            sq_op_r   <= div_quo_nxt[wca_pkg::SQ_IN_W-1:0];
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= '0;
            st_r      <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_op_r   <= {sq_op_r[wca_pkg::SQ_IN_W-3:0], 2'b00};
          sq_rem_r  <= sq_rem_nxt;
          sq_root_r <= sq_root_nxt;
          sq_cnt_r  <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 5'(wca_pkg::SQ_STEPS - 1)) begin
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          sp_r          <= sp_sat[wca_pkg::SPR_W-1:0];
          ch_r          <= (sp_sat[wca_pkg::SPR_W-1:0] > prev_spread_r)
                           ? sp_sat[wca_pkg::SPR_W-1:0] - prev_spread_r
                           : prev_spread_r - sp_sat[wca_pkg::SPR_W-1:0];
          prev_spread_r <= sp_sat[wca_pkg::SPR_W-1:0];
          area_sum_r    <= '0;
          asq_sum_r     <= '0;
          st_r          <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (item_r.mode == wca_pkg::MODE_FINISH) begin
              out_r <= {wca_pkg::KIND_STATS, 11'd0, 16'd0, 16'd0,
                        {wca_pkg::AREA_W{1'b0}}, sp_r, ch_r};
            end else begin
              out_r <= {wca_pkg::KIND_CENTROID, item_r.cell_req, px_r, py_r, a_r,
                        {wca_pkg::SPR_W{1'b0}}, {wca_pkg::SPR_W{1'b0}}};
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // No word is taken during the clearing sweep.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLEAR) |-> !in_ready) else $error("word taken during clear");

  // A result only appears out of the output state.
  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_OUT)) else $error("stray result");

  // Centroid results carry no statistics.
  a_centroid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == wca_pkg::KIND_CENTROID)
      |-> (out_r.spread == '0 && out_r.spread_change == '0))
    else $error("centroid word carries spread");

  // Write-back goes to the entry that was read.
  a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RMW && ram_we) |-> (ram_waddr == $past(ram_raddr)))
    else $error("write-back address mismatch");
`endif

endmodule
`default_nettype wire

// File: dv/weighted_centroid_accumulator_test.sv
// Testbench: directed table and random frames checked against a Lloyd step predictor.
`timescale 1ns / 1ps
module weighted_centroid_accumulator_test;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  wca_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  wca_pkg::out_word_t out_word;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_addr = wca_pkg::CFG_CELL_COUNT;
  logic [12:0] cfg_wdata = '0;

  weighted_centroid_accumulator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: per-cell sums, frame statistics, registers
  bit [63:0] mass_mem [wca_pkg::MAX_CELLS];
  bit [63:0] xmom_mem [wca_pkg::MAX_CELLS];
  bit [63:0] ymom_mem [wca_pkg::MAX_CELLS];
  bit [63:0] area_mem [wca_pkg::MAX_CELLS];
  bit [63:0] frame_area_sum, frame_area_sq, last_spread;
  bit [63:0] reg_cells, reg_width, reg_height, reg_floor;

  wca_pkg::out_word_t expected_words[$];
  int        mismatches = 0;
  int        words_sent = 0;
  int        centroids_seen = 0;
  int        stats_seen = 0;
  int        tx_idle = 0;
  int        rx_idle = 0;

  function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b, int w);
    bit [63:0] lim;
    lim = (64'd1 << w) - 64'd1;
    if (a >= lim || b >= lim - a) return lim;
    return a + b;
  endfunction

  function automatic bit [63:0] isqrt64(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit [63:0] centroid_q4(bit [63:0] mom, bit [63:0] m, bit [63:0] dim);
    bit [63:0] q, cap;
    q = (m != 0) ? (mom << 4) / m : 64'd0;
    cap = dim * 64'd16;
    if (cap > 64'd65535) cap = 64'd65535;
    return (q > cap) ? cap : q;
  endfunction

  // Advance the predictor by one accepted word; returns 1 if a result is due
  function automatic bit predict_lloyd_step(wca_pkg::in_word_t w,
                                            output wca_pkg::out_word_t r);
    bit [63:0] d, m, xm, ym, a, n, n2, ns, s2, dv, q, sp, ch;
    int c;
    r = '0;
    c = int'(w.cell_req);
    case (w.mode)
      wca_pkg::MODE_ACC: begin
        d = 64'd255 - 64'(w.gray);
        if (d < reg_floor) d = reg_floor;
        mass_mem[c] = sat_sum(mass_mem[c], d, wca_pkg::MASS_W);
        xmom_mem[c] = sat_sum(xmom_mem[c], 64'(w.pixel_x) * d, wca_pkg::MOM_W);
        ymom_mem[c] = sat_sum(ymom_mem[c], 64'(w.pixel_y) * d, wca_pkg::MOM_W);
        area_mem[c] = sat_sum(area_mem[c], 64'd1, wca_pkg::AREA_W);
        return 0;
      end
      wca_pkg::MODE_READ: begin
        m = mass_mem[c]; xm = xmom_mem[c]; ym = ymom_mem[c]; a = area_mem[c];
        mass_mem[c] = 0; xmom_mem[c] = 0; ymom_mem[c] = 0; area_mem[c] = 0;
        if (m < reg_floor) m = reg_floor;
        frame_area_sum = sat_sum(frame_area_sum, a, wca_pkg::AREA_W);
        frame_area_sq = sat_sum(frame_area_sq, a * a, wca_pkg::ASQ_W);
        r.kind = wca_pkg::KIND_CENTROID;
        r.cell_out = w.cell_req;
        r.point_x = 16'(centroid_q4(xm, m, reg_width));
        r.point_y = 16'(centroid_q4(ym, m, reg_height));
        r.area = wca_pkg::AREA_W'(a);
        return 1;
      end
      wca_pkg::MODE_FINISH: begin
        n = (reg_cells != 0) ? reg_cells : 64'd1;
        n2 = n * n;
        ns = n * frame_area_sq;
        s2 = frame_area_sum * frame_area_sum;
        dv = (ns > s2) ? ns - s2 : 64'd0;
        q = (dv / n2) * 64'd256 + ((dv % n2) * 64'd256) / n2;
        sp = isqrt64(q);
        if (sp > (64'd1 << wca_pkg::SPR_W) - 64'd1) sp = (64'd1 << wca_pkg::SPR_W) - 64'd1;
        ch = (sp > last_spread) ? sp - last_spread : last_spread - sp;
        last_spread = sp;
        frame_area_sum = 0;
        frame_area_sq = 0;
        r.kind = wca_pkg::KIND_STATS;
        r.spread = wca_pkg::SPR_W'(sp);
        r.spread_change = wca_pkg::SPR_W'(ch);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Result side: random stalls, compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    wca_pkg::out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_word);
      end else begin
        e = expected_words.pop_front();
        if (out_word.kind == wca_pkg::KIND_STATS) stats_seen++; else centroids_seen++;
        if (out_word.kind !== e.kind || out_word.cell_out !== e.cell_out ||
            out_word.point_x !== e.point_x || out_word.point_y !== e.point_y ||
            out_word.area !== e.area || out_word.spread !== e.spread ||
            out_word.spread_change !== e.spread_change) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected kind %0d cell %0d x %0d y %0d area %0d",
                     e.kind, e.cell_out, e.point_x, e.point_y, e.area);
            $display("          expected spr %0d chg %0d", e.spread, e.spread_change);
            $display("          got kind %0d cell %0d x %0d y %0d area %0d",
                     out_word.kind, out_word.cell_out, out_word.point_x,
                     out_word.point_y, out_word.area);
            $display("          got spr %0d chg %0d", out_word.spread,
                     out_word.spread_change);
          end
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= rx_idle);
  end

  // Send one word; a typed expectation replaces the predicted one
  task automatic send_word(wca_pkg::in_word_t w, bit typed, wca_pkg::out_word_t typed_exp);
    wca_pkg::out_word_t p;
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (predict_lloyd_step(w, p)) expected_words.push_back(typed ? typed_exp : p);
  endtask

  // Register write while idle: drain results, then let dropped words finish
  task automatic write_regs(bit [12:0] cc, bit [12:0] iw, bit [12:0] ih, bit [12:0] fl);
    bit [12:0] vals [4];
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    vals = '{cc, iw, ih, fl};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    reg_cells = 64'(cc & 13'hfff);
    reg_width = 64'(iw);
    reg_height = 64'(ih);
    reg_floor = 64'(fl & 13'hff);
  endtask

  function automatic wca_pkg::in_word_t mk(bit [1:0] md, bit [11:0] x, bit [11:0] y,
                                           bit [7:0] g, bit [10:0] c);
    wca_pkg::in_word_t w;
    w.mode = md; w.pixel_x = x; w.pixel_y = y; w.gray = g; w.cell_req = c;
    return w;
  endfunction

  function automatic wca_pkg::in_word_t random_pixel(bit [10:0] c);
    bit [7:0] g;
    g = $urandom_range(3) == 0 ? ($urandom_range(1) ? 8'd0 : 8'd255) : 8'($urandom);
    return mk(wca_pkg::MODE_ACC, 12'($urandom), 12'($urandom), g, c);
  endfunction

  typedef struct {
    wca_pkg::in_word_t  w;
    bit                 typed;
    wca_pkg::out_word_t e;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    bit [10:0] pool [4];
    wca_pkg::out_word_t none;
    wca_pkg::out_word_t t;
    int n_pix;
    none = '0;
    for (int i = 0; i < wca_pkg::MAX_CELLS; i++) begin
      mass_mem[i] = 0; xmom_mem[i] = 0; ymom_mem[i] = 0; area_mem[i] = 0;
    end
    frame_area_sum = 0; frame_area_sq = 0; last_spread = 0;
    reg_cells = 1280; reg_width = 4096; reg_height = 4096; reg_floor = 3;

    // Directed table: empty readout, empty frame, unused mode, field extremes
    t = '0; t.cell_out = 11'd0;
    dir_rows.push_back('{mk(wca_pkg::MODE_READ, 0, 0, 0, 0), 1, t});
    t = '0; t.kind = wca_pkg::KIND_STATS;
    dir_rows.push_back('{mk(wca_pkg::MODE_FINISH, 0, 0, 0, 0), 1, t});
    dir_rows.push_back('{mk(2'd3, 12'hfff, 12'hfff, 8'hff, 11'h7ff), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_ACC, 12'hfff, 12'hfff, 8'd0, 11'h7ff), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_ACC, 12'd0, 12'd0, 8'd255, 11'h7ff), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_READ, 0, 0, 0, 11'h7ff), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_ACC, 12'd100, 12'd200, 8'd128, 11'd1), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_ACC, 12'd7, 12'd4000, 8'd254, 11'd1), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_READ, 0, 0, 0, 11'd1), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_ACC, 12'hfff, 12'd0, 8'd0, 11'd3), 0, none});
    t = '0; t.cell_out = 11'd3; t.point_x = 16'd65520; t.area = 25'd1;
    dir_rows.push_back('{mk(wca_pkg::MODE_READ, 0, 0, 0, 11'd3), 1, t});
    dir_rows.push_back('{mk(wca_pkg::MODE_FINISH, 0, 0, 0, 0), 0, none});
    dir_rows.push_back('{mk(2'd3, 12'h555, 12'haaa, 8'h5a, 11'h2aa), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_READ, 0, 0, 0, 11'd1), 0, none});
    dir_rows.push_back('{mk(wca_pkg::MODE_FINISH, 0, 0, 0, 0), 0, none});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle = 34; rx_idle = 85;
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].e);

    // Random frames under four register settings, extremes included
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_regs(13'd1280, 13'd4096, 13'd4096, 13'd3);
        1: write_regs(13'd0, 13'd1, 13'd1, 13'd0);
        2: write_regs(13'd2048, 13'd4096, 13'd4096, 13'd255);
        default: write_regs(13'($urandom_range(1, 2048)), 13'($urandom_range(1, 4096)),
                            13'($urandom_range(1, 4096)), 13'($urandom_range(0, 255)));
      endcase
      while (words_sent < 15 + 300 * (ph + 1)) begin
        for (int k = 0; k < 4; k++)
          pool[k] = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 11'h7ff : 11'd0)
                                             : 11'($urandom);
        n_pix = $urandom_range(5, 40);
        for (int k = 0; k < n_pix; k++) begin
          if (words_sent < 400) begin tx_idle = 34; rx_idle = 85; end
          else if (words_sent < 800) begin tx_idle = 85; rx_idle = 34; end
          else begin tx_idle = 0; rx_idle = 0; end
          if ($urandom_range(99) < 8)
            send_word(mk(2'($urandom), 12'($urandom), 12'($urandom), 8'($urandom),
                         11'($urandom)), 0, none);
          else
            send_word(random_pixel(pool[$urandom_range(3)]), 0, none);
        end
        for (int k = 0; k < 4; k++)
          if ($urandom_range(9) != 0)
            send_word(mk(wca_pkg::MODE_READ, 12'($urandom), 12'($urandom),
                         8'($urandom), pool[k]), 0, none);
        if ($urandom_range(4) != 0)
          send_word(mk(wca_pkg::MODE_FINISH, 12'($urandom), 12'($urandom), 8'($urandom),
                       11'($urandom)), 0, none);
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d words over four register settings;", words_sent);
    $display("checked %0d centroids and %0d frame results.", centroids_seen, stats_seen);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("timeout, %0d results outstanding", expected_words.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
